// File: rtl/ialu_pf_pkg.sv
// Package with the shared widths, opcodes and sequencer states of the integer ALU.
package ialu_pf_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int OPCODE_W    = 3;
  localparam int IN_FIELDS_W = OPCODE_W + 2 * DATA_WIDTH;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

  // Beyond this n the factorial holds at least DATA_WIDTH factors of two.
  localparam int FACT_LIMIT = 2 * DATA_WIDTH + 2;
  localparam int CNT_W      = $clog2(FACT_LIMIT + 1);

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_POWER     = 3'd0,
    OP_MULTIPLY  = 3'd1,
    OP_FACTORIAL = 3'd2,
    OP_ADD       = 3'd3,
    OP_SUBTRACT  = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_POW,
    ST_FACT,
    ST_DONE
  } state_t;

endpackage

// File: rtl/integer_alu_power_factorial.sv
// Top level of the integer ALU: add, subtract, multiply, power and factorial.
//
// Requests arrive on the in_ stream channel: in_tdata carries the opcode and
// two signed operands, and one request is taken when in_tvalid and in_tready
// are both high. Each request produces exactly one 32-bit result on the out_
// stream channel. All operations wrap modulo 2^32 as two's complement; unused
// opcodes return zero.
// The block works on one request at a time and in_tready is high only while
// the sequencer is idle. Add, subtract and unused opcodes load their result on
// acceptance; multiply passes through the multiply state first. Power uses
// square-and-multiply on one shared 32x32 multiplier, one product per cycle.
// Factorial runs the same multiplier once per factor for n from 2 to 66; for
// n below 2 or above 66 the result (1 or 0) is loaded on acceptance.
// The shared multiplier sets the rate.
// The result sits in an output register; if the receiver stalls, the block
// holds the finished result in its done state until the register frees, so
// nothing is lost or repeated. Synchronous active-low reset returns the
// sequencer to idle and empties the output register.
module integer_alu_power_factorial (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0 up: opcode[2:0], operand_a[34:3], operand_b[66:35], zero pad.
  input  logic [ialu_pf_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0 up: result_value[31:0].
  output logic [ialu_pf_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int W     = ialu_pf_pkg::DATA_WIDTH;
  localparam int OW    = ialu_pf_pkg::OPCODE_W;
  localparam int CNT_W = ialu_pf_pkg::CNT_W;
  localparam int OUT_W = ialu_pf_pkg::OUT_TDATA_W;

  ialu_pf_pkg::state_t  state_r, state_nxt;
  ialu_pf_pkg::word_t   acc_r, acc_nxt;
  ialu_pf_pkg::word_t   base_r, base_nxt;
  // Exponent for power, second operand for multiply, n for factorial.
  ialu_pf_pkg::word_t   exp_r, exp_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ialu_pf_pkg::word_t   out_data_r, out_data_nxt;

  ialu_pf_pkg::opcode_t in_op;
  ialu_pf_pkg::word_t   in_a, in_b, in_sum, in_diff;
  logic                 in_accept;
  logic                 out_free;

  ialu_pf_pkg::word_t   mul_x, mul_y;
  logic [2*W-1:0]       mul_full;
  ialu_pf_pkg::word_t   mul_lo;

  assign in_op   = ialu_pf_pkg::opcode_t'(in_tdata[OW-1:0]);
  assign in_a    = in_tdata[OW+W-1:OW];
  assign in_b    = in_tdata[OW+2*W-1:OW+W];
  assign in_sum  = in_a + in_b;
  assign in_diff = in_a - in_b;

  assign in_tready = (state_r == ialu_pf_pkg::ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);

  // Shared multiplier; only the low word of the product is kept.
  always_comb begin
    mul_x = base_r;
    mul_y = exp_r;
    case (state_r)
      ialu_pf_pkg::ST_POW: begin
        // A set low exponent bit multiplies into the accumulator, otherwise square.
        mul_x = exp_r[0] ? acc_r : base_r;
        mul_y = base_r;
      end
      ialu_pf_pkg::ST_FACT: begin
        mul_x = acc_r;
        mul_y = {{(W-CNT_W){1'b0}}, cnt_r};
      end
      default: begin
        mul_x = base_r;
        mul_y = exp_r;
      end
    endcase
  end

  assign mul_full = mul_x * mul_y;
  assign mul_lo   = mul_full[W-1:0];

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ialu_pf_pkg::ST_IDLE: begin
        if (in_accept) begin
          unique case (in_op)
            ialu_pf_pkg::OP_MULTIPLY: state_nxt = ialu_pf_pkg::ST_MUL;
            ialu_pf_pkg::OP_POWER: begin
              if (in_b[W-1] || in_b == '0) begin
                state_nxt = ialu_pf_pkg::ST_DONE;
              end else begin
                state_nxt = ialu_pf_pkg::ST_POW;
              end
            end
            ialu_pf_pkg::OP_FACTORIAL: begin
              if (in_a[W-1] || in_a <= W'(1) || in_a > W'(ialu_pf_pkg::FACT_LIMIT)) begin
                state_nxt = ialu_pf_pkg::ST_DONE;
              end else begin
                state_nxt = ialu_pf_pkg::ST_FACT;
              end
            end
            default: state_nxt = ialu_pf_pkg::ST_DONE;
          endcase
        end
      end
      ialu_pf_pkg::ST_MUL: state_nxt = ialu_pf_pkg::ST_DONE;
      ialu_pf_pkg::ST_POW: begin
        if (exp_r == '0) begin
          state_nxt = ialu_pf_pkg::ST_DONE;
        end
      end
      ialu_pf_pkg::ST_FACT: begin
        if (cnt_r == exp_r[CNT_W-1:0]) begin
          state_nxt = ialu_pf_pkg::ST_DONE;
        end
      end
      ialu_pf_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = ialu_pf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ialu_pf_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    exp_nxt       = exp_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ialu_pf_pkg::ST_IDLE: begin
        if (in_accept) begin
          acc_nxt  = W'(1);
          base_nxt = in_a;
          exp_nxt  = in_b;
          cnt_nxt  = CNT_W'(2);
          unique case (in_op)
            ialu_pf_pkg::OP_ADD:      acc_nxt = in_sum;
            ialu_pf_pkg::OP_SUBTRACT: acc_nxt = in_diff;
            ialu_pf_pkg::OP_POWER,
            ialu_pf_pkg::OP_MULTIPLY: acc_nxt = W'(1);
            ialu_pf_pkg::OP_FACTORIAL: begin
              exp_nxt = in_a;
              if (!in_a[W-1] && in_a > W'(ialu_pf_pkg::FACT_LIMIT)) begin
                acc_nxt = '0;
              end
            end
            default: acc_nxt = '0;
          endcase
        end
      end
      ialu_pf_pkg::ST_MUL: acc_nxt = mul_lo;
      ialu_pf_pkg::ST_POW: begin
        if (exp_r != '0) begin
          if (exp_r[0]) begin
            acc_nxt = mul_lo;
            exp_nxt = {exp_r[W-1:1], 1'b0};
          end else begin
            base_nxt = mul_lo;
            exp_nxt  = {1'b0, exp_r[W-1:1]};
          end
        end
      end
      ialu_pf_pkg::ST_FACT: begin
        acc_nxt = mul_lo;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      ialu_pf_pkg::ST_DONE: begin
        if (out_free) begin
          out_data_nxt  = acc_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ialu_pf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    base_r     <= base_nxt;
    exp_r      <= exp_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // The factorial counter never runs past n.
  a_fact_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ialu_pf_pkg::ST_FACT) |->
      (cnt_r >= CNT_W'(2) && cnt_r <= exp_r[CNT_W-1:0]))
    else $error("factorial counter out of range");

  // Power never loops on a negative exponent.
  a_pow_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ialu_pf_pkg::ST_POW) |-> !exp_r[W-1])
    else $error("power loop entered with negative exponent");

  // An accepted add leaves its sum in the accumulator, ready to deliver.
  a_add_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_op == ialu_pf_pkg::OP_ADD) |=>
      (state_r == ialu_pf_pkg::ST_DONE && acc_r == $past(in_sum)))
    else $error("add result not loaded");

  // A finished result waits while the output register is still occupied.
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ialu_pf_pkg::ST_DONE && out_valid_r && !out_tready) |=>
      (state_r == ialu_pf_pkg::ST_DONE && out_valid_r))
    else $error("result dropped while receiver stalled");

  // No request is taken while a result is being computed.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ialu_pf_pkg::ST_IDLE) |-> !in_tready)
    else $error("request accepted while busy");

endmodule

// File: dv/tb_integer_alu_power_factorial.sv
// Self-checking testbench for the integer ALU with power and factorial.
`timescale 1ns / 100ps

module tb_integer_alu_power_factorial;

  // Opcode values the block does not define; each one must return zero.
  localparam logic [ialu_pf_pkg::OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [ialu_pf_pkg::OPCODE_W-1:0] OP_SPARE_MID   = 3'd6;
  localparam logic [ialu_pf_pkg::OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;

  localparam int DW              = ialu_pf_pkg::DATA_WIDTH;
  localparam int RANDOM_REQUESTS = 450;
  localparam int QUIET_TAIL      = 60;    // final requests sent with no idling on either side
  localparam int STALL_LIMIT     = 2000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES    = 80;    // longer than the slowest power request

  typedef logic [ialu_pf_pkg::OPCODE_W-1:0] op_t;

  typedef struct {
    op_t                opcode;
    ialu_pf_pkg::word_t operand_a;
    ialu_pf_pkg::word_t operand_b;
    logic               typed;         // result below was written down by hand
    ialu_pf_pkg::word_t typed_result;
  } directed_row_t;

  logic                                clk        = 1'b0;
  logic                                rst_n      = 1'b0;
  logic                                in_tvalid  = 1'b0;
  logic                                in_tready;
  logic [ialu_pf_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                                out_tvalid;
  logic                                out_tready = 1'b1;
  logic [ialu_pf_pkg::OUT_TDATA_W-1:0] out_tdata;

  logic               quiet_tail = 1'b0;
  directed_row_t      directed_rows[$];
  ialu_pf_pkg::word_t pending_results[$];
  ialu_pf_pkg::word_t oldest_result;
  int                 error_count     = 0;
  int                 results_checked = 0;
  int                 idle_cycles     = 0;
  int                 requests_by_op[8];

  integer_alu_power_factorial u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Expected result of one request, everything wrapped to DATA_WIDTH bits.
  function automatic ialu_pf_pkg::word_t alu_expected(input op_t op,
                                                      input ialu_pf_pkg::word_t a,
                                                      input ialu_pf_pkg::word_t b);
    ialu_pf_pkg::word_t acc;
    ialu_pf_pkg::word_t square;
    ialu_pf_pkg::word_t expo;
    int                 k;
    acc = 1;
    case (op)
      ialu_pf_pkg::OP_POWER: begin
        // A negative or zero exponent leaves the product at one.
        if (!b[DW-1] && b != 0) begin
          square = a;
          expo   = b;
          while (expo != 0) begin
            if (expo[0]) acc = acc * square;
            square = square * square;
            expo   = expo >> 1;
          end
        end
      end
      ialu_pf_pkg::OP_MULTIPLY:  acc = a * b;
      ialu_pf_pkg::OP_FACTORIAL: begin
        // n of one or less, negative n included, gives one; past the limit the
        // product holds DATA_WIDTH factors of two and wraps to zero.
        if (!a[DW-1] && a > 1) begin
          if (a > ialu_pf_pkg::FACT_LIMIT) begin
            acc = 0;
          end else begin
            for (k = 2; k <= a; k++) acc = acc * ialu_pf_pkg::word_t'(k);
          end
        end
      end
      ialu_pf_pkg::OP_ADD:      acc = a + b;
      ialu_pf_pkg::OP_SUBTRACT: acc = a - b;
      default:                  acc = 0;
    endcase
    return acc;
  endfunction

  function automatic ialu_pf_pkg::word_t rand_operand();
    case ($urandom_range(0, 7))
      0, 1, 2: return $urandom;
      3:       return ialu_pf_pkg::word_t'($urandom_range(0, 16)) - ialu_pf_pkg::word_t'(8);
      4: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  task automatic add_row(input op_t op, input ialu_pf_pkg::word_t a,
                         input ialu_pf_pkg::word_t b, input logic typed,
                         input ialu_pf_pkg::word_t typed_result);
    directed_row_t row;
    row.opcode       = op;
    row.operand_a    = a;
    row.operand_b    = b;
    row.typed        = typed;
    row.typed_result = typed_result;
    directed_rows.push_back(row);
  endtask

  // Presents one request, optionally after an idle burst, and records its
  // expected result at the edge where it is taken.
  task automatic send_request(input op_t op, input ialu_pf_pkg::word_t a,
                              input ialu_pf_pkg::word_t b, input ialu_pf_pkg::word_t want,
                              input logic allow_gap);
    logic [ialu_pf_pkg::IN_TDATA_W-1:0] packed_req;
    packed_req                                             = '0;
    packed_req[ialu_pf_pkg::OPCODE_W-1:0]                  = op;
    packed_req[ialu_pf_pkg::OPCODE_W +: DW]                = a;
    packed_req[ialu_pf_pkg::OPCODE_W + DW +: DW]           = b;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= packed_req;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(want);
    requests_by_op[op]++;
  endtask

  // The receiver stalls in bursts, except during the quiet tail of the run.
  always begin
    @(posedge clk);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
      out_tready <= 1'b1;
    end
  end

  // Every result must match the oldest outstanding request.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result %h with no request outstanding", out_tdata));
      end else begin
        oldest_result = pending_results.pop_front();
        results_checked++;
        if (out_tdata[DW-1:0] !== oldest_result) begin
          flag_mismatch($sformatf("result_value %h, expected %h",
                                  out_tdata[DW-1:0], oldest_result));
        end
      end
    end
  end

  // Watchdog: a run that stops moving is a failure.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TIMEOUT @%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("tb_integer_alu_power_factorial: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    op_t                op;
    ialu_pf_pkg::word_t a;
    ialu_pf_pkg::word_t b;
    ialu_pf_pkg::word_t want;
    foreach (requests_by_op[i]) requests_by_op[i] = 0;

    // Wrap at the extremes of add, subtract and multiply.
    add_row(ialu_pf_pkg::OP_ADD,      32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 32'h8000_0000);
    add_row(ialu_pf_pkg::OP_ADD,      32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000);
    add_row(ialu_pf_pkg::OP_SUBTRACT, 32'h8000_0000, 32'h0000_0001, 1'b1, 32'h7FFF_FFFF);
    add_row(ialu_pf_pkg::OP_SUBTRACT, 32'h0000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000);
    add_row(ialu_pf_pkg::OP_MULTIPLY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001);
    add_row(ialu_pf_pkg::OP_MULTIPLY, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000);
    add_row(ialu_pf_pkg::OP_MULTIPLY, 32'h7FFF_FFFF, 32'h1234_5679, 1'b0, '0);
    // Power: zero and negative exponents, wrap, and the longest exponent.
    add_row(ialu_pf_pkg::OP_POWER,    32'h0000_0005, 32'h0000_0000, 1'b1, 32'h0000_0001);
    add_row(ialu_pf_pkg::OP_POWER,    32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0001);
    add_row(ialu_pf_pkg::OP_POWER,    32'h0000_0000, 32'h0000_0005, 1'b1, 32'h0000_0000);
    add_row(ialu_pf_pkg::OP_POWER,    32'h0000_0002, 32'h0000_001F, 1'b1, 32'h8000_0000);
    add_row(ialu_pf_pkg::OP_POWER,    32'h0000_0002, 32'h0000_0020, 1'b1, 32'h0000_0000);
    add_row(ialu_pf_pkg::OP_POWER,    32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    add_row(ialu_pf_pkg::OP_POWER,    32'h0000_0003, 32'h7FFF_FFFF, 1'b0, '0);
    // Factorial: small and negative n, the last nonzero n, and the cutoff.
    add_row(ialu_pf_pkg::OP_FACTORIAL, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001);
    add_row(ialu_pf_pkg::OP_FACTORIAL, 32'h0000_0001, 32'h0000_0000, 1'b1, 32'h0000_0001);
    add_row(ialu_pf_pkg::OP_FACTORIAL, 32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0000_0001);
    add_row(ialu_pf_pkg::OP_FACTORIAL, 32'h0000_000C, 32'h0000_0000, 1'b0, '0);
    add_row(ialu_pf_pkg::OP_FACTORIAL, 32'h0000_0021, 32'h0000_0000, 1'b0, '0);
    add_row(ialu_pf_pkg::OP_FACTORIAL, 32'h0000_0022, 32'h0000_0000, 1'b1, 32'h0000_0000);
    add_row(ialu_pf_pkg::OP_FACTORIAL, 32'h0000_0043, 32'h0000_0000, 1'b1, 32'h0000_0000);
    add_row(ialu_pf_pkg::OP_FACTORIAL, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000);
    // Undefined opcodes return zero whatever the operands.
    add_row(OP_SPARE_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
    add_row(OP_SPARE_LAST,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      want = directed_rows[i].typed ? directed_rows[i].typed_result
                                    : alu_expected(directed_rows[i].opcode,
                                                   directed_rows[i].operand_a,
                                                   directed_rows[i].operand_b);
      send_request(directed_rows[i].opcode, directed_rows[i].operand_a,
                   directed_rows[i].operand_b, want, 1'b1);
    end

    // Hold off until the block has answered every directed request.
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS - QUIET_TAIL) quiet_tail <= 1'b1;
      case ($urandom_range(0, 15))
        0, 1, 2: begin
          op = ialu_pf_pkg::OP_POWER;
          a  = rand_operand();
          case ($urandom_range(0, 3))
            0, 1: b = $urandom_range(0, 40);
            2:    b = $urandom;
            default: b = ialu_pf_pkg::word_t'(0) - ialu_pf_pkg::word_t'($urandom_range(1, 8));
          endcase
        end
        3, 4, 5: begin
          op = ialu_pf_pkg::OP_MULTIPLY;
          a  = rand_operand();
          b  = rand_operand();
        end
        6, 7, 8: begin
          op = ialu_pf_pkg::OP_FACTORIAL;
          a  = ($urandom_range(0, 4) == 0) ? ialu_pf_pkg::word_t'($urandom)
                                           : ialu_pf_pkg::word_t'($urandom_range(0, 70));
          b  = $urandom;
        end
        9, 10, 11: begin
          op = ialu_pf_pkg::OP_ADD;
          a  = rand_operand();
          b  = rand_operand();
        end
        12, 13, 14: begin
          op = ialu_pf_pkg::OP_SUBTRACT;
          a  = rand_operand();
          b  = rand_operand();
        end
        default: begin
          op = op_t'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
          a  = $urandom;
          b  = $urandom;
        end
      endcase
      send_request(op, a, b, alu_expected(op, a, b), i < RANDOM_REQUESTS - QUIET_TAIL);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      flag_mismatch($sformatf("%0d requests never answered", pending_results.size()));
    end

    $display("Summary: %0d results checked; power %0d, multiply %0d, factorial %0d,",
             results_checked, requests_by_op[ialu_pf_pkg::OP_POWER],
             requests_by_op[ialu_pf_pkg::OP_MULTIPLY],
             requests_by_op[ialu_pf_pkg::OP_FACTORIAL]);
    $display("  add %0d, subtract %0d, undefined opcodes %0d, with stalls on both sides.",
             requests_by_op[ialu_pf_pkg::OP_ADD], requests_by_op[ialu_pf_pkg::OP_SUBTRACT],
             requests_by_op[OP_SPARE_FIRST] + requests_by_op[OP_SPARE_MID]
             + requests_by_op[OP_SPARE_LAST]);
    if (error_count == 0) begin
      $display("tb_integer_alu_power_factorial: done, clean");
    end else begin
      $display("tb_integer_alu_power_factorial: done, errors");
    end
    $finish;
  end

endmodule
